/* rtl/planar_velocity_magnitude_limiter_top_defines.svh */
// Assertion macros for the planar velocity magnitude limiter.
// Taken in by the RTL files that check their own behavior; expects clk and rst in scope.
`ifndef PLANAR_VELOCITY_MAGNITUDE_LIMITER_TOP_DEFINES_SVH
`define PLANAR_VELOCITY_MAGNITUDE_LIMITER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define PVML_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define PVML_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pvml_pkg.sv */
// Shared types and constants for the planar velocity magnitude limiter.
// No dependencies; used by planar_velocity_magnitude_limiter_top.
`timescale 1ns / 1ps
`default_nettype none

package pvml_pkg;

  // Field and datapath widths.
  localparam int VW      = 16;           // velocity field width
  localparam int PC_W    = 8;            // people count width
  localparam int LIM_W   = 11;           // speed limit width
  localparam int ABS_W   = VW + 1;       // magnitude of one component
  localparam int SUM_W   = 2 * VW;       // x^2 + y^2
  localparam int ROOT_W  = SUM_W / 2;    // floor(sqrt(x^2 + y^2))
  localparam int PROD_W  = ABS_W + LIM_W; // |component| * limit
  localparam int CNT_W   = 5;            // step counter, holds up to PROD_W

  // Clamp applied to writes of the maximum speed.
  localparam logic [LIM_W-1:0] CFG_THRESHOLD = 11'd1229;
  localparam logic [LIM_W-1:0] CFG_CAPPED    = 11'd1638;

  typedef struct packed {
    logic signed [VW-1:0]   vel_x;
    logic signed [VW-1:0]   vel_y;
    logic signed [VW-1:0]   vel_z;
    logic signed [VW-1:0]   rot_x;
    logic signed [VW-1:0]   rot_y;
    logic signed [VW-1:0]   rot_z;
    logic signed [PC_W-1:0] people_count;
  } cmd_in_t;

  typedef struct packed {
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic signed [VW-1:0] out_rot_x;
    logic signed [VW-1:0] out_rot_y;
    logic signed [VW-1:0] out_rot_z;
  } cmd_out_t;

endpackage

`default_nettype wire

/* rtl/planar_velocity_magnitude_limiter_top.sv */
// Planar velocity magnitude limiter: ramped speed limit and planar clamp of a velocity command.
// Depends on pvml_pkg and planar_velocity_magnitude_limiter_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one velocity command at a time and returns one limited command for each.
// The planar speed limit follows the maximum written on the cfg port: it snaps to the
// maximum whenever people are present and on the first command without people after
// reset, and otherwise ramps up toward it by a truncated 1/RAMP_DIVISOR of the gap per
// command. When sqrt(x^2 + y^2) exceeds the limit, x and y are scaled by limit/magnitude
// with truncation toward zero; z and the angular parts pass through. All arithmetic runs
// on one bit-serial multiplier, one bit-serial restoring divider and a two-bit-per-cycle
// square root, sequenced one phase after another. The scaling phases (MULX, DIVX, MULY,
// DIVY) run only when the magnitude exceeds the limit; the next command is taken the cycle
// after the result is loaded into the output register. The output register lets a finished
// result wait while the next command is worked on.
module planar_velocity_magnitude_limiter_top #(
  parameter int RAMP_DIVISOR = 50
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire pvml_pkg::cmd_in_t       in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output pvml_pkg::cmd_out_t           out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [pvml_pkg::LIM_W-1:0]    cfg_data
);

  localparam int VW     = pvml_pkg::VW;
  localparam int LIM_W  = pvml_pkg::LIM_W;
  localparam int ABS_W  = pvml_pkg::ABS_W;
  localparam int SUM_W  = pvml_pkg::SUM_W;
  localparam int ROOT_W = pvml_pkg::ROOT_W;
  localparam int PROD_W = pvml_pkg::PROD_W;
  localparam int CNT_W  = pvml_pkg::CNT_W;

  // Sequencer state codes.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RAMP = 4'd1;
  localparam logic [3:0] S_SQX  = 4'd2;
  localparam logic [3:0] S_SQY  = 4'd3;
  localparam logic [3:0] S_ROOT = 4'd4;
  localparam logic [3:0] S_MULX = 4'd5;
  localparam logic [3:0] S_DIVX = 4'd6;
  localparam logic [3:0] S_MULY = 4'd7;
  localparam logic [3:0] S_DIVY = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  // Control state.
  logic [3:0]       state;
  logic [3:0]       state_next;
  logic             started;
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] max_limit;
  logic [CNT_W-1:0] cnt;

  // Captured command.
  logic signed [VW-1:0] res_x;
  logic signed [VW-1:0] res_y;
  logic signed [VW-1:0] vz;
  logic signed [VW-1:0] rx;
  logic signed [VW-1:0] ry;
  logic signed [VW-1:0] rz;
  logic                 sx;
  logic                 sy;
  logic [ABS_W-1:0]     ax;
  logic [ABS_W-1:0]     ay;

  // Bit-serial multiplier.
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] mcand;
  logic [ABS_W-1:0] mplier;
  logic [SUM_W-1:0] mul_sum;

  // Bit-serial restoring divider.
  logic [PROD_W-1:0] dnum;
  logic [ROOT_W-1:0] drem;
  logic [ROOT_W-1:0] dden;
  logic [ROOT_W:0]   div_trial;
  logic [ROOT_W:0]   div_diff;
  logic              div_ge;
  logic [ROOT_W-1:0] drem_next;
  logic [PROD_W-1:0] dnum_next;
  logic [VW-1:0]     quot;

  // Two-bit-per-cycle square root.
  logic [SUM_W-1:0]  sq;
  logic [ROOT_W+1:0] srem;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W+1:0] sqrt_shift;
  logic [ROOT_W+1:0] sqrt_trial;
  logic              sqrt_ge;
  logic [ROOT_W+1:0] srem_next;
  logic [ROOT_W-1:0] root_next;
  logic              exceed;

  // Command decode at transfer.
  logic              in_fire;
  logic              nobody;
  logic [LIM_W-1:0]  base;
  logic [LIM_W-1:0]  gap;
  logic [ABS_W-1:0]  x_ext;
  logic [ABS_W-1:0]  y_ext;
  logic [ABS_W-1:0]  ax_in;
  logic [ABS_W-1:0]  ay_in;

  logic out_free;
  logic step_last;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign step_last = (cnt == CNT_W'(1));

  // Limit base and ramp gap for the incoming command.
  always_comb begin
    nobody = (in_data.people_count == '0);
    base   = (nobody && started) ? limit : max_limit;
    gap    = (nobody && (base < max_limit)) ? (max_limit - base) : '0;
    x_ext  = {in_data.vel_x[VW-1], in_data.vel_x};
    y_ext  = {in_data.vel_y[VW-1], in_data.vel_y};
    ax_in  = in_data.vel_x[VW-1] ? (~x_ext + ABS_W'(1)) : x_ext;
    ay_in  = in_data.vel_y[VW-1] ? (~y_ext + ABS_W'(1)) : y_ext;
  end

  // One shift-and-add step of the multiplier.
  assign mul_sum = acc + (mplier[0] ? mcand : '0);

  // One restoring step of the divider; quotient bits enter dnum from the bottom.
  always_comb begin
    div_trial = {drem, dnum[PROD_W-1]};
    div_diff  = div_trial - {1'b0, dden};
    div_ge    = (div_trial >= {1'b0, dden});
    drem_next = div_ge ? div_diff[ROOT_W-1:0] : div_trial[ROOT_W-1:0];
    dnum_next = {dnum[PROD_W-2:0], div_ge};
    quot      = dnum_next[VW-1:0];
  end

  // One digit step of the square root, consuming the next two bits of the sum.
  always_comb begin
    sqrt_shift = {srem[ROOT_W-1:0], sq[SUM_W-1 -: 2]};
    sqrt_trial = {root, 2'b01};
    sqrt_ge    = (sqrt_shift >= sqrt_trial);
    srem_next  = sqrt_ge ? (sqrt_shift - sqrt_trial) : sqrt_shift;
    root_next  = {root[ROOT_W-2:0], sqrt_ge};
    exceed     = (root_next > ROOT_W'(limit)) ||
                 ((root_next == ROOT_W'(limit)) && (srem_next != '0));
  end

  // Phase sequencing.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_RAMP;
      S_RAMP: if (step_last) state_next = S_SQX;
      S_SQX:  if (step_last) state_next = S_SQY;
      S_SQY:  if (step_last) state_next = S_ROOT;
      S_ROOT: if (step_last) state_next = exceed ? S_MULX : S_DONE;
      S_MULX: if (step_last) state_next = S_DIVX;
      S_DIVX: if (step_last) state_next = S_MULY;
      S_MULY: if (step_last) state_next = S_DIVY;
      S_DIVY: if (step_last) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers: sequencer, speed limit, ramp flag, maximum, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      limit     <= '0;
      max_limit <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_limit <= (cfg_data > pvml_pkg::CFG_THRESHOLD) ? pvml_pkg::CFG_CAPPED : cfg_data;
      end
      if (in_fire) begin
        started <= started | nobody;
        limit   <= base;
      end
      if ((state == S_RAMP) && step_last) begin
        limit <= limit + dnum_next[LIM_W-1:0];
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Datapath registers for every phase.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          res_x <= in_data.vel_x;
          res_y <= in_data.vel_y;
          vz    <= in_data.vel_z;
          rx    <= in_data.rot_x;
          ry    <= in_data.rot_y;
          rz    <= in_data.rot_z;
          sx    <= in_data.vel_x[VW-1];
          sy    <= in_data.vel_y[VW-1];
          ax    <= ax_in;
          ay    <= ay_in;
          dnum  <= {gap, {(PROD_W - LIM_W){1'b0}}};
          drem  <= '0;
          dden  <= ROOT_W'(RAMP_DIVISOR);
          cnt   <= CNT_W'(LIM_W);
        end
      end
      S_RAMP: begin
        dnum <= dnum_next;
        drem <= drem_next;
        cnt  <= cnt - CNT_W'(1);
        if (step_last) begin
          acc    <= '0;
          mcand  <= SUM_W'(ax);
          mplier <= ax;
          cnt    <= CNT_W'(ABS_W);
        end
      end
      S_SQX: begin
        acc    <= mul_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNT_W'(1);
        if (step_last) begin
          mcand  <= SUM_W'(ay);
          mplier <= ay;
          cnt    <= CNT_W'(ABS_W);
        end
      end
      S_SQY: begin
        acc    <= mul_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNT_W'(1);
        if (step_last) begin
          sq   <= mul_sum;
          srem <= '0;
          root <= '0;
          cnt  <= CNT_W'(ROOT_W);
        end
      end
      S_ROOT: begin
        sq   <= sq << 2;
        srem <= srem_next;
        root <= root_next;
        cnt  <= cnt - CNT_W'(1);
        if (step_last) begin
          acc    <= '0;
          mcand  <= SUM_W'(ax);
          mplier <= ABS_W'(limit);
          cnt    <= CNT_W'(LIM_W);
        end
      end
      S_MULX, S_MULY: begin
        acc    <= mul_sum;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - CNT_W'(1);
        if (step_last) begin
          dnum <= mul_sum[PROD_W-1:0];
          drem <= '0;
          dden <= root;
          cnt  <= CNT_W'(PROD_W);
        end
      end
      S_DIVX: begin
        dnum <= dnum_next;
        drem <= drem_next;
        cnt  <= cnt - CNT_W'(1);
        if (step_last) begin
          res_x  <= sx ? -quot : quot;
          acc    <= '0;
          mcand  <= SUM_W'(ay);
          mplier <= ABS_W'(limit);
          cnt    <= CNT_W'(LIM_W);
        end
      end
      S_DIVY: begin
        dnum <= dnum_next;
        drem <= drem_next;
        cnt  <= cnt - CNT_W'(1);
        if (step_last) begin
          res_y <= sy ? -quot : quot;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_data.out_x     <= res_x;
          out_data.out_y     <= res_y;
          out_data.out_z     <= vz;
          out_data.out_rot_x <= rx;
          out_data.out_rot_y <= ry;
          out_data.out_rot_z <= rz;
        end
      end
      default: begin
      end
    endcase
  end

`include "planar_velocity_magnitude_limiter_top_defines.svh"

  // The limit can never rise above the capped maximum.
  `PVML_ASSERT_NOW(a_limit_capped, 1'b1, limit <= pvml_pkg::CFG_CAPPED, "limit above cap")

  // Once the ramp has started it stays started.
  `PVML_ASSERT_NEXT(a_ramp_sticky, started, started, "ramp flag cleared")

  // A command with people present leaves the limit at the maximum.
  `PVML_ASSERT_NEXT(a_people_snap, in_fire && (in_data.people_count != '0) && !cfg_valid, limit == max_limit, "limit did not snap to maximum")

  // Scaling divides only by a nonzero magnitude.
  `PVML_ASSERT_NOW(a_div_nonzero, (state == S_DIVX) || (state == S_DIVY), dden != '0, "divide by zero magnitude")

  // A finished result waits while the output register is still held.
  `PVML_ASSERT_NEXT(a_done_holds, (state == S_DONE) && out_valid && !out_ready, state == S_DONE, "result overwrote held output")

endmodule

`default_nettype wire

/* sim/planar_velocity_magnitude_limiter_top_tb.sv */
// Self-checking testbench for planar_velocity_magnitude_limiter_top.
// Depends on pvml_pkg and the limiter RTL; a built-in predictor checks every result.
`timescale 1ns / 1ps

module planar_velocity_magnitude_limiter_top_tb;

  localparam int VW          = pvml_pkg::VW;
  localparam int LIM_W       = pvml_pkg::LIM_W;
  localparam int RAMP_STEPS  = 50;
  localparam int PHASES      = 14;
  localparam int PER_PHASE   = 96;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    bit                load_max;
    int                max_value;
    pvml_pkg::cmd_in_t cmd;
    bit                known;
    int                want_x;
    int                want_y;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  pvml_pkg::cmd_in_t  in_data;
  logic               out_valid;
  logic               out_ready;
  pvml_pkg::cmd_out_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIM_W-1:0]   cfg_data;

  // Predictor state: stored maximum, running limit and whether the ramp has started.
  logic [LIM_W-1:0]   shadow_max;
  logic [15:0]        shadow_limit;
  logic               shadow_started;

  pvml_pkg::cmd_out_t expected_limited[$];
  directed_row_t      directed_rows[$];
  pvml_pkg::cmd_out_t oldest;
  int                 fails = 0;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  bit                 rx_calm = 1'b0;

  planar_velocity_magnitude_limiter_top #(
    .RAMP_DIVISOR(RAMP_STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Largest r with r*r <= n, found one bit at a time.
  function automatic longint floor_root(longint n);
    longint r;
    longint t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Scales one planar component by lim/root, truncating toward zero.
  function automatic logic signed [VW-1:0] scale_part(logic signed [VW-1:0] v, longint lim,
                                                      longint root);
    longint a;
    longint q;
    a = (v < 0) ? -longint'(v) : longint'(v);
    q = (a * lim) / root;
    return (v < 0) ? VW'(-q) : VW'(q);
  endfunction

  // Advances the running limit for one command and returns the limited command.
  function automatic pvml_pkg::cmd_out_t limit_command(pvml_pkg::cmd_in_t c);
    longint ax;
    longint ay;
    longint sum;
    longint lim;
    longint root;
    pvml_pkg::cmd_out_t r;
    if (c.people_count == 0) begin
      if (!shadow_started) begin
        shadow_limit = 16'(shadow_max);
        shadow_started = 1'b1;
      end
      if (shadow_limit < 16'(shadow_max))
        shadow_limit = shadow_limit + (16'(shadow_max) - shadow_limit) / 16'(RAMP_STEPS);
    end else begin
      shadow_limit = 16'(shadow_max);
    end
    lim = longint'(shadow_limit);
    ax = (c.vel_x < 0) ? -longint'(c.vel_x) : longint'(c.vel_x);
    ay = (c.vel_y < 0) ? -longint'(c.vel_y) : longint'(c.vel_y);
    sum = ax * ax + ay * ay;
    r.out_x = c.vel_x;
    r.out_y = c.vel_y;
    if (sum > lim * lim) begin
      root = floor_root(sum);
      r.out_x = scale_part(c.vel_x, lim, root);
      r.out_y = scale_part(c.vel_y, lim, root);
    end
    r.out_z = c.vel_z;
    r.out_rot_x = c.rot_x;
    r.out_rot_y = c.rot_y;
    r.out_rot_z = c.rot_z;
    return r;
  endfunction

  function automatic directed_row_t dir_row(bit load, int max_value, int x, int y, int pc,
                                            int z, int rx, int ry, int rz,
                                            bit known, int wx, int wy);
    directed_row_t d;
    d.load_max = load;
    d.max_value = max_value;
    d.cmd.vel_x = x;
    d.cmd.vel_y = y;
    d.cmd.vel_z = z;
    d.cmd.rot_x = rx;
    d.cmd.rot_y = ry;
    d.cmd.rot_z = rz;
    d.cmd.people_count = pc;
    d.known = known;
    d.want_x = wx;
    d.want_y = wy;
    return d;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic int extreme_value();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 32767;
    endcase
  endfunction

  // Random command; the planar part leans toward values near and below the limit.
  function automatic pvml_pkg::cmd_in_t rand_cmd(bit nobody);
    pvml_pkg::cmd_in_t c;
    int x;
    int y;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        x = int'($urandom_range(0, 4095)) - 2048;
        y = int'($urandom_range(0, 4095)) - 2048;
      end
      4, 5, 6: begin
        x = $urandom();
        y = $urandom();
      end
      7: begin
        x = extreme_value();
        y = extreme_value();
      end
      8: begin
        x = int'(shadow_limit) + int'($urandom_range(0, 8)) - 4;
        y = $urandom_range(0, 3);
        if ($urandom_range(0, 1)) x = -x;
        if ($urandom_range(0, 1)) y = -y;
      end
      default: begin
        x = 0;
        y = $urandom();
        if ($urandom_range(0, 1)) begin
          x = y;
          y = 0;
        end
      end
    endcase
    c.vel_x = x;
    c.vel_y = y;
    c.vel_z = $urandom();
    c.rot_x = $urandom();
    c.rot_y = $urandom();
    c.rot_z = $urandom();
    c.people_count = nobody ? 8'd0 : 8'($urandom_range(1, 255));
    return c;
  endfunction

  // Holds off new commands until every outstanding result has been transferred.
  task automatic drain_commands();
    in_valid <= 1'b0;
    while (expected_limited.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Writes the maximum speed once the block is idle.
  task automatic write_max_speed(int value);
    drain_commands();
    cfg_valid <= 1'b1;
    cfg_data <= LIM_W'(value);
    do @(posedge clk); while (!cfg_ready);
    shadow_max = (LIM_W'(value) > pvml_pkg::CFG_THRESHOLD) ? pvml_pkg::CFG_CAPPED :
                 LIM_W'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one command after a gap and records its expected result at the transfer.
  task automatic send_command(pvml_pkg::cmd_in_t c, int gap, bit known, int wx, int wy);
    pvml_pkg::cmd_out_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    r = limit_command(c);
    if (known) begin
      r.out_x = wx;
      r.out_y = wy;
    end
    expected_limited.push_back(r);
    @(negedge clk);
  endtask

  function automatic void check_part(string name, logic [VW-1:0] want, logic [VW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fails++;
    end
  endfunction

  // Result side: random stalls, with calm stretches where ready stays high.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 9) == 0) stall_left = pick_gap();
    end
  end

  // Each result transfer is compared against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_limited.size() == 0) begin
        $error("result transfer with no command outstanding");
        fails++;
      end else begin
        oldest = expected_limited.pop_front();
        check_part("out_x", oldest.out_x, out_data.out_x);
        check_part("out_y", oldest.out_y, out_data.out_y);
        check_part("out_z", oldest.out_z, out_data.out_z);
        check_part("out_rot_x", oldest.out_rot_x, out_data.out_rot_x);
        check_part("out_rot_y", oldest.out_rot_y, out_data.out_rot_y);
        check_part("out_rot_z", oldest.out_rot_z, out_data.out_rot_z);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int run_left;
    bit nobody;
    bit calm;
    int max_value;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;
    shadow_max = '0;
    shadow_limit = '0;
    shadow_started = 1'b0;
    run_left = 0;
    nobody = 1'b0;

    // Directed rows: load, max, x, y, people, z, rot x/y/z, known, want x, want y.
    // Reset maximum is zero: nothing planar gets through.
    directed_rows.push_back(dir_row(0, 0, 0, 0, 0, 32767, -32768, 'h5555, -21846, 1, 0, 0));
    directed_rows.push_back(dir_row(0, 0, 100, -50, 0, -1, 1, 0, 2, 1, 0, 0));
    directed_rows.push_back(dir_row(0, 0, -32768, -32768, 1, 0, 32767, -1, -32768, 1, 0, 0));
    // Write above the threshold is capped; people present snaps the limit up.
    directed_rows.push_back(dir_row(1, 2047, 1000, 0, 5, 12, -12, 300, -300, 1, 1000, 0));
    directed_rows.push_back(dir_row(0, 0, 32767, 0, 5, -5, 5, 7, -7, 1, 1638, 0));
    // A negative people count still counts as people present.
    directed_rows.push_back(dir_row(0, 0, -32768, 0, -1, 4096, -4096, 8, 9, 1, -1638, 0));
    directed_rows.push_back(dir_row(0, 0, 0, -32768, 127, 1, 2, 3, 4, 1, 0, -1638));
    directed_rows.push_back(dir_row(0, 0, 3000, 4000, -128, -2, -3, -4, -5, 1, 982, 1310));
    // Magnitude exactly at the limit passes; one count over goes through the scaler.
    directed_rows.push_back(dir_row(1, 1230, 1638, 0, 5, 10, 20, 30, 40, 1, 1638, 0));
    directed_rows.push_back(dir_row(0, 0, 1638, 1, 5, -10, -20, -30, -40, 1, 1638, 1));
    // Lowering the maximum without people leaves the limit where it was.
    directed_rows.push_back(dir_row(1, 1229, 1638, 0, 0, 77, 88, 99, 111, 1, 1638, 0));
    directed_rows.push_back(dir_row(0, 0, 32767, 32767, 0, 5, 6, 7, 8, 0, 0, 0));
    directed_rows.push_back(dir_row(0, 0, 32767, -32768, 3, -6, -7, -8, -9, 0, 0, 0));
    directed_rows.push_back(dir_row(1, 0, 500, 500, 2, 0, 0, 0, 0, 1, 0, 0));
    // Ramp from zero toward a raised maximum.
    for (int i = 0; i < 5; i++)
      directed_rows.push_back(dir_row(i == 0, 1200, -20000, 15000, 0, i, -i, 2 * i, -2 * i,
                                      0, 0, 0));
    // A gap below the divisor adds nothing, so a zero limit stays zero.
    directed_rows.push_back(dir_row(1, 0, 7, 7, 1, 3, 3, 3, 3, 1, 0, 0));
    directed_rows.push_back(dir_row(1, 40, 7, 7, 0, 4, 4, 4, 4, 1, 0, 0));
    directed_rows.push_back(dir_row(0, 0, 1, 0, 0, 5, 5, 5, 5, 1, 0, 0));
    // Smallest nonzero limit, with truncation toward zero on negative parts.
    directed_rows.push_back(dir_row(1, 1, 1, 0, 1, 6, 6, 6, 6, 1, 1, 0));
    directed_rows.push_back(dir_row(0, 0, 1, 1, 1, 7, 7, 7, 7, 1, 1, 1));
    directed_rows.push_back(dir_row(0, 0, -1, -2, 1, 8, 8, 8, 8, 1, 0, -1));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load_max) write_max_speed(directed_rows[i].max_value);
      send_command(directed_rows[i].cmd, 0, directed_rows[i].known,
                   directed_rows[i].want_x, directed_rows[i].want_y);
    end

    // Random phases; low and high maximums alternate so the ramp runs a long way.
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph % 4 == 3);
      rx_calm = calm;
      case (ph)
        0: max_value = 0;
        1: max_value = 2047;
        2: max_value = 1;
        3: max_value = 1229;
        4: max_value = 1230;
        5: max_value = 0;
        6: max_value = 1638;
        default: max_value = (ph % 2) ? $urandom_range(1100, 2047) : $urandom_range(0, 400);
      endcase
      write_max_speed(max_value);
      for (int k = 0; k < PER_PHASE; k++) begin
        // Commands come in runs with nobody present, broken by short runs with people.
        if (run_left == 0) begin
          nobody = ($urandom_range(0, 9) < 7);
          run_left = nobody ? $urandom_range(5, 40) : $urandom_range(1, 5);
        end
        run_left--;
        if ($urandom_range(0, 59) == 0) drain_commands();
        send_command(rand_cmd(nobody), calm ? 0 : pick_gap(), 0, 0, 0);
      end
    end

    drain_commands();
    repeat (200) @(negedge clk);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* planar_velocity_magnitude_limiter_top.f */
+incdir+rtl
rtl/pvml_pkg.sv
rtl/planar_velocity_magnitude_limiter_top.sv
sim/planar_velocity_magnitude_limiter_top_tb.sv
